// File: rtl/gzhp_pkg.sv
// ----------------------------------------------------------------------------
// gzhp_pkg
// Shared types and constants for the gzip member header parser.
// ----------------------------------------------------------------------------
package gzhp_pkg;

  // Widths of the stream and result fields
  localparam int unsigned ActionWidth = 2;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned SkipWidth   = 16;
  localparam int unsigned FlagWidth   = 4;

  // Header constants
  localparam logic [ByteWidth-1:0] Magic1       = 8'd31;
  localparam logic [ByteWidth-1:0] Magic2       = 8'd139;
  localparam logic [ByteWidth-1:0] MethodDeflate = 8'd8;
  localparam logic [ByteWidth-1:0] FlagReserved = 8'he0;
  localparam logic [SkipWidth-1:0] FixedSkip    = 16'd6;
  localparam logic [SkipWidth-1:0] HcrcSkip     = 16'd2;

  // Stored flag bits (flag byte bits 1..4)
  localparam int unsigned FlagHcrc    = 0;
  localparam int unsigned FlagExtra   = 1;
  localparam int unsigned FlagName    = 2;
  localparam int unsigned FlagComment = 3;

  // Action codes on the input stream; the fourth code is ignored
  typedef enum logic [ActionWidth-1:0] {
    ACT_DATA    = 2'd0,
    ACT_END     = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  // Result status codes
  typedef enum logic [StatusWidth-1:0] {
    ST_TAKEN   = 3'd0,
    ST_DONE    = 3'd1,
    ST_PAYLOAD = 3'd2,
    ST_MAGIC   = 3'd3,
    ST_METHOD  = 3'd4,
    ST_RESFLAG = 3'd5,
    ST_TRUNC   = 3'd6,
    ST_ENDOK   = 3'd7
  } status_t;

endpackage

// File: rtl/gzhp_if.sv
// ----------------------------------------------------------------------------
// gzhp_if
// Valid/ready channels for the gzip header parser: byte stream in, result out.
// ----------------------------------------------------------------------------

// Input byte stream channel
interface gzhp_in_if;
  logic                             valid;
  logic                             ready;
  logic [gzhp_pkg::ActionWidth-1:0] action;
  logic [gzhp_pkg::ByteWidth-1:0]   data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// Result channel
interface gzhp_out_if;
  logic                             valid;
  logic                             ready;
  logic [gzhp_pkg::StatusWidth-1:0] status;
  logic [gzhp_pkg::ByteWidth-1:0]   payload_byte;
  logic                             payload_valid;

  modport source (output valid, output status, output payload_byte,
                  output payload_valid, input ready);
  modport sink   (input valid, input status, input payload_byte,
                  input payload_valid, output ready);
endinterface

// File: rtl/gzip_header_parser.sv
// ----------------------------------------------------------------------------
// gzip_header_parser
// The result of a stream transfer stands in the output register in the cycle after the transfer.
// Throughput: one byte per cycle; the output register takes a new result in the
// same cycle that the held one is transferred, so a stalled sink alone holds it.
// Reset (rst, synchronous): header phase back to first magic byte, error
// cleared, output register empty. A restart action does the same in-band for phase and error, but yields a result.
// ----------------------------------------------------------------------------
module gzip_header_parser (
  input  logic              clk,
  input  logic              rst,
  gzhp_in_if.sink           stream,
  gzhp_out_if.source        result
);

  // Header phases, one-hot
  typedef enum logic [11:0] {
    PH_MAGIC1  = 12'b0000_0000_0001,
    PH_MAGIC2  = 12'b0000_0000_0010,
    PH_METHOD  = 12'b0000_0000_0100,
    PH_FLAGS   = 12'b0000_0000_1000,
    PH_SKIP6   = 12'b0000_0001_0000,
    PH_XLEN_LO = 12'b0000_0010_0000,
    PH_XLEN_HI = 12'b0000_0100_0000,
    PH_XSKIP   = 12'b0000_1000_0000,
    PH_NAME    = 12'b0001_0000_0000,
    PH_COMMENT = 12'b0010_0000_0000,
    PH_HCRC    = 12'b0100_0000_0000,
    PH_PAYLOAD = 12'b1000_0000_0000
  } phase_t;

  // Sections that can follow the fixed part of the header
  typedef enum logic [1:0] {
    SEC_EXTRA   = 2'd0,
    SEC_NAME    = 2'd1,
    SEC_COMMENT = 2'd2,
    SEC_HCRC    = 2'd3
  } section_t;

  // Parser state
  phase_t                            phase, phase_next;
  logic [gzhp_pkg::FlagWidth-1:0]    flags, flags_next;
  logic [gzhp_pkg::SkipWidth-1:0]    skip, skip_next;
  logic [gzhp_pkg::ByteWidth-1:0]    xlen_low, xlen_low_next;
  gzhp_pkg::status_t                 err, err_next;

  // Output register
  logic                              out_valid;
  gzhp_pkg::status_t                 out_status, status_next;
  logic [gzhp_pkg::ByteWidth-1:0]    out_byte, byte_next;
  logic                              out_pvalid, pvalid_next;

  logic                              take;
  logic                              in_payload;
  logic [gzhp_pkg::SkipWidth-1:0]    skip_dec;
  logic [gzhp_pkg::SkipWidth-1:0]    xlen;

  // First present section at or after the given one
  function automatic phase_t next_section(input section_t from,
                                          input logic [gzhp_pkg::FlagWidth-1:0] f);
    phase_t p;
    if (from == SEC_EXTRA && f[gzhp_pkg::FlagExtra]) begin
      p = PH_XLEN_LO;
    end else if (from != SEC_COMMENT && from != SEC_HCRC && f[gzhp_pkg::FlagName]) begin
      p = PH_NAME;
    end else if (from != SEC_HCRC && f[gzhp_pkg::FlagComment]) begin
      p = PH_COMMENT;
    end else if (f[gzhp_pkg::FlagHcrc]) begin
      p = PH_HCRC;
    end else begin
      p = PH_PAYLOAD;
    end
    return p;
  endfunction

  // Handshake: a new byte is taken whenever the output register is free
  assign stream.ready = !out_valid || result.ready;
  assign take         = stream.valid && stream.ready;

  assign skip_dec = skip - gzhp_pkg::SkipWidth'(1);
  assign xlen     = {stream.data_byte, xlen_low};

  // Anything that is not a header phase counts as payload
  always_comb begin
    unique case (phase)
      PH_MAGIC1, PH_MAGIC2, PH_METHOD, PH_FLAGS, PH_SKIP6, PH_XLEN_LO,
      PH_XLEN_HI, PH_XSKIP, PH_NAME, PH_COMMENT, PH_HCRC: in_payload = 1'b0;
      default:                                             in_payload = 1'b1;
    endcase
  end

  // Next state and result for the byte on the stream
  always_comb begin
    phase_next    = phase;
    flags_next    = flags;
    skip_next     = skip;
    xlen_low_next = xlen_low;
    err_next      = err;
    status_next   = gzhp_pkg::ST_TAKEN;
    byte_next     = '0;
    pvalid_next   = 1'b0;

    case (stream.action)
      gzhp_pkg::ACT_RESTART: begin
        phase_next    = PH_MAGIC1;
        flags_next    = '0;
        skip_next     = '0;
        xlen_low_next = '0;
        err_next      = gzhp_pkg::ST_TAKEN;
      end
      gzhp_pkg::ACT_END: begin
        if (err != gzhp_pkg::ST_TAKEN) begin
          status_next = err;
        end else if (in_payload) begin
          status_next = gzhp_pkg::ST_ENDOK;
        end else begin
          err_next    = gzhp_pkg::ST_TRUNC;
          status_next = gzhp_pkg::ST_TRUNC;
        end
      end
      gzhp_pkg::ACT_DATA: begin
        if (err != gzhp_pkg::ST_TAKEN) begin
          status_next = err;
        end else if (in_payload) begin
          status_next = gzhp_pkg::ST_PAYLOAD;
          byte_next   = stream.data_byte;
          pvalid_next = 1'b1;
        end else begin
          // Header byte
          unique case (phase)
            PH_MAGIC1: begin
              if (stream.data_byte != gzhp_pkg::Magic1) begin
                err_next = gzhp_pkg::ST_MAGIC;
              end else begin
                phase_next = PH_MAGIC2;
              end
            end
            PH_MAGIC2: begin
              if (stream.data_byte != gzhp_pkg::Magic2) begin
                err_next = gzhp_pkg::ST_MAGIC;
              end else begin
                phase_next = PH_METHOD;
              end
            end
            PH_METHOD: begin
              if (stream.data_byte != gzhp_pkg::MethodDeflate) begin
                err_next = gzhp_pkg::ST_METHOD;
              end else begin
                phase_next = PH_FLAGS;
              end
            end
            PH_FLAGS: begin
              if ((stream.data_byte & gzhp_pkg::FlagReserved) != '0) begin
                err_next = gzhp_pkg::ST_RESFLAG;
              end else begin
                flags_next = stream.data_byte[gzhp_pkg::FlagWidth:1];
                skip_next  = gzhp_pkg::FixedSkip;
                phase_next = PH_SKIP6;
              end
            end
            PH_SKIP6: begin
              skip_next = skip_dec;
              if (skip_dec == '0) phase_next = next_section(SEC_EXTRA, flags);
            end
            PH_XLEN_LO: begin
              xlen_low_next = stream.data_byte;
              phase_next    = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
              skip_next = xlen;
              if (xlen == '0) begin
                phase_next = next_section(SEC_NAME, flags);
              end else begin
                phase_next = PH_XSKIP;
              end
            end
            PH_XSKIP: begin
              skip_next = skip_dec;
              if (skip_dec == '0) phase_next = next_section(SEC_NAME, flags);
            end
            PH_NAME: begin
              if (stream.data_byte == '0) phase_next = next_section(SEC_COMMENT, flags);
            end
            PH_COMMENT: begin
              if (stream.data_byte == '0) phase_next = next_section(SEC_HCRC, flags);
            end
            PH_HCRC: begin
              skip_next = skip_dec;
              if (skip_dec == '0) phase_next = PH_PAYLOAD;
            end
            default: ;
          endcase

          // Entering the header CRC loads its two-byte count
          if (phase_next == PH_HCRC && phase != PH_HCRC) skip_next = gzhp_pkg::HcrcSkip;

          if (err_next != gzhp_pkg::ST_TAKEN) begin
            status_next = err_next;
          end else if (phase_next == PH_PAYLOAD) begin
            status_next = gzhp_pkg::ST_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_MAGIC1;
      flags    <= '0;
      skip     <= '0;
      xlen_low <= '0;
      err      <= gzhp_pkg::ST_TAKEN;
    end else if (take) begin
      phase    <= phase_next;
      flags    <= flags_next;
      skip     <= skip_next;
      xlen_low <= xlen_low_next;
      err      <= err_next;
    end
  end

  // Output register: valid is control, payload loads on each transfer in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status <= status_next;
      out_byte   <= byte_next;
      out_pvalid <= pvalid_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.payload_byte  = out_byte;
  assign result.payload_valid = out_pvalid;

`ifndef SYNTHESIS
  // Payload flag agrees with the payload status code
  a_pvalid_status: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.payload_valid == (result.status == gzhp_pkg::ST_PAYLOAD)))
    else $error("payload_valid disagrees with status");

  // Non-payload results carry a zero byte
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.payload_valid) |-> (result.payload_byte == '0))
    else $error("payload_byte not zero outside payload");

  // Errors arise only inside the header
  a_err_header: assert property (@(posedge clk) disable iff (rst)
    (err != gzhp_pkg::ST_TAKEN) |-> (phase != PH_PAYLOAD))
    else $error("sticky error set in payload phase");

  // Every byte taken yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> result.valid)
    else $error("transfer in without result");
`endif

endmodule

// File: tb/gzip_header_parser_tb.sv
// ----------------------------------------------------------------------------
// gzip_header_parser_tb
// Self-checking bench for the gzip member header parser. A queue of stream
// items (well-formed members with random content, corrupted and cut headers,
// noise) feeds a valid/ready driver. A local model of the header walk
// predicts one result per accepted transfer, and the monitor compares every
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gzip_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 4;
  // Fourth action code: the block ignores it and reports a taken byte
  localparam logic [gzhp_pkg::ActionWidth-1:0] ActIgnored = 2'd3;

  // Header walk position, local to the bench
  typedef enum logic [3:0] {
    HDR_MAGIC1, HDR_MAGIC2, HDR_METHOD, HDR_FLAGS, HDR_SKIP6, HDR_XLEN_LO,
    HDR_XLEN_HI, HDR_XSKIP, HDR_NAME, HDR_COMMENT, HDR_HCRC, HDR_PAYLOAD
  } hdr_phase_t;

  typedef struct packed {
    logic [gzhp_pkg::ActionWidth-1:0] action;
    logic [gzhp_pkg::ByteWidth-1:0]   data_byte;
  } stream_item_t;

  typedef struct packed {
    gzhp_pkg::status_t              status;
    logic [gzhp_pkg::ByteWidth-1:0] payload_byte;
    logic                           payload_valid;
  } parse_result_t;

  logic clk;
  logic rst;

  gzhp_in_if  stream_if ();
  gzhp_out_if result_if ();

  gzip_header_parser dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  stream_item_t  pending_items[$];
  parse_result_t expected_results[$];
  int unsigned   item_count;
  int unsigned   total_items;
  int unsigned   sent_count;
  int unsigned   err_count;
  int unsigned   cycle_count;

  // Model state
  hdr_phase_t                     hdr_phase;
  logic [gzhp_pkg::FlagWidth-1:0] hdr_flags;
  logic [gzhp_pkg::SkipWidth-1:0] skip_left;
  logic [gzhp_pkg::ByteWidth-1:0] xlen_low;
  gzhp_pkg::status_t              sticky_status;  // ST_TAKEN means no error

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic void clear_parse_state();
    hdr_phase     = HDR_MAGIC1;
    hdr_flags     = '0;
    skip_left     = '0;
    xlen_low      = '0;
    sticky_status = gzhp_pkg::ST_TAKEN;
  endfunction

  // Next optional section from stage 0 extra, 1 name, 2 comment, 3 CRC
  function automatic hdr_phase_t next_section(int unsigned stage);
    if (stage == 0 && hdr_flags[gzhp_pkg::FlagExtra]) return HDR_XLEN_LO;
    if (stage <= 1 && hdr_flags[gzhp_pkg::FlagName]) return HDR_NAME;
    if (stage <= 2 && hdr_flags[gzhp_pkg::FlagComment]) return HDR_COMMENT;
    if (hdr_flags[gzhp_pkg::FlagHcrc]) begin
      skip_left = gzhp_pkg::HcrcSkip;
      return HDR_HCRC;
    end
    return HDR_PAYLOAD;
  endfunction

  function automatic parse_result_t predict_result(
      logic [gzhp_pkg::ActionWidth-1:0] act, logic [gzhp_pkg::ByteWidth-1:0] b);
    parse_result_t     r;
    hdr_phase_t        nxt;
    gzhp_pkg::status_t err;
    r   = '{status: gzhp_pkg::ST_TAKEN, payload_byte: '0, payload_valid: 1'b0};
    nxt = hdr_phase;
    err = gzhp_pkg::ST_TAKEN;
    if (act == gzhp_pkg::ACT_RESTART) begin
      clear_parse_state();
    end else if (act == ActIgnored) begin
      // no state change
    end else if (sticky_status != gzhp_pkg::ST_TAKEN) begin
      r.status = sticky_status;
    end else if (act == gzhp_pkg::ACT_END) begin
      if (hdr_phase >= HDR_PAYLOAD) begin
        r.status = gzhp_pkg::ST_ENDOK;
      end else begin
        sticky_status = gzhp_pkg::ST_TRUNC;
        r.status      = gzhp_pkg::ST_TRUNC;
      end
    end else if (hdr_phase >= HDR_PAYLOAD) begin
      r.status        = gzhp_pkg::ST_PAYLOAD;
      r.payload_byte  = b;
      r.payload_valid = 1'b1;
    end else begin
      case (hdr_phase)
        HDR_MAGIC1: begin
          if (b != gzhp_pkg::Magic1) err = gzhp_pkg::ST_MAGIC;
          else nxt = HDR_MAGIC2;
        end
        HDR_MAGIC2: begin
          if (b != gzhp_pkg::Magic2) err = gzhp_pkg::ST_MAGIC;
          else nxt = HDR_METHOD;
        end
        HDR_METHOD: begin
          if (b != gzhp_pkg::MethodDeflate) err = gzhp_pkg::ST_METHOD;
          else nxt = HDR_FLAGS;
        end
        HDR_FLAGS: begin
          if ((b & gzhp_pkg::FlagReserved) != '0) begin
            err = gzhp_pkg::ST_RESFLAG;
          end else begin
            hdr_flags = b[4:1];
            skip_left = gzhp_pkg::FixedSkip;
            nxt       = HDR_SKIP6;
          end
        end
        HDR_SKIP6: begin
          skip_left = skip_left - gzhp_pkg::SkipWidth'(1);
          if (skip_left == '0) nxt = next_section(0);
        end
        HDR_XLEN_LO: begin
          xlen_low = b;
          nxt      = HDR_XLEN_HI;
        end
        HDR_XLEN_HI: begin
          skip_left = {b, xlen_low};
          nxt = (skip_left == '0) ? next_section(1) : HDR_XSKIP;
        end
        HDR_XSKIP: begin
          skip_left = skip_left - gzhp_pkg::SkipWidth'(1);
          if (skip_left == '0) nxt = next_section(1);
        end
        HDR_NAME: begin
          if (b == '0) nxt = next_section(2);
        end
        HDR_COMMENT: begin
          if (b == '0) nxt = next_section(3);
        end
        HDR_HCRC: begin
          skip_left = skip_left - gzhp_pkg::SkipWidth'(1);
          if (skip_left == '0) nxt = HDR_PAYLOAD;
        end
        default: ;
      endcase
      if (err != gzhp_pkg::ST_TAKEN) begin
        sticky_status = err;
        r.status      = err;
      end else begin
        if (nxt == HDR_PAYLOAD) r.status = gzhp_pkg::ST_DONE;
        hdr_phase = nxt;
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus
  function automatic void add_item(logic [gzhp_pkg::ActionWidth-1:0] act,
                                   logic [gzhp_pkg::ByteWidth-1:0] b);
    pending_items.push_back('{action: act, data_byte: b});
    if (act != ActIgnored) item_count++;
  endfunction

  // Data byte, now and then preceded by an ignored code
  function automatic void add_byte(logic [gzhp_pkg::ByteWidth-1:0] b);
    if ($urandom_range(39) == 0) add_item(ActIgnored, 8'($urandom));
    add_item(gzhp_pkg::ACT_DATA, b);
  endfunction

  // One member: restart, header, payload, end; some corrupted or cut short
  function automatic void add_member();
    logic [gzhp_pkg::ByteWidth-1:0] hdr[$];
    logic [gzhp_pkg::ByteWidth-1:0] flg;
    logic [gzhp_pkg::SkipWidth-1:0] xlen;
    int unsigned                    kind;
    int unsigned                    cut;
    kind = $urandom_range(99);
    flg  = 8'($urandom_range(0, 31));
    hdr  = '{gzhp_pkg::Magic1, gzhp_pkg::Magic2, gzhp_pkg::MethodDeflate, flg};
    repeat (6) hdr.push_back(8'($urandom));
    if (flg[gzhp_pkg::FlagExtra+1]) begin
      if ($urandom_range(59) == 0) xlen = {8'h01, 8'($urandom)};
      else xlen = 16'($urandom_range(0, 6));
      hdr.push_back(xlen[7:0]);
      hdr.push_back(xlen[15:8]);
      repeat (xlen) hdr.push_back(8'($urandom));
    end
    if (flg[gzhp_pkg::FlagName+1]) begin
      repeat ($urandom_range(0, 4)) hdr.push_back(8'($urandom_range(1, 255)));
      hdr.push_back(8'd0);
    end
    if (flg[gzhp_pkg::FlagComment+1]) begin
      repeat ($urandom_range(0, 4)) hdr.push_back(8'($urandom_range(1, 255)));
      hdr.push_back(8'd0);
    end
    if (flg[gzhp_pkg::FlagHcrc+1]) repeat (2) hdr.push_back(8'($urandom));
    // broken headers
    if (kind < 4) hdr[0] ^= 8'($urandom_range(1, 255));
    else if (kind < 8) hdr[1] ^= 8'($urandom_range(1, 255));
    else if (kind < 12) hdr[2] ^= 8'($urandom_range(1, 255));
    else if (kind < 16) hdr[3] |= {3'($urandom_range(1, 7)), 5'd0};
    if ($urandom_range(19) != 0) add_item(gzhp_pkg::ACT_RESTART, 8'($urandom));
    if (kind >= 16 && kind < 24) begin
      // end inside the header, then bytes against the sticky error
      cut = $urandom_range(0, hdr.size() - 1);
      for (int i = 0; i < cut; i++) add_byte(hdr[i]);
      add_item(gzhp_pkg::ACT_END, 8'($urandom));
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
    end else begin
      foreach (hdr[i]) add_byte(hdr[i]);
      repeat ($urandom_range(0, 12)) add_byte(8'($urandom));
      if ($urandom_range(99) < 85) add_item(gzhp_pkg::ACT_END, 8'($urandom));
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
    end
  endfunction

  // Idle percentage by third of the run: sender light/receiver heavy, then swapped, then none
  function automatic int unsigned idle_pct(bit sender);
    if (sent_count < total_items / 3) return sender ? 8 : 85;
    if (sent_count < 2 * total_items / 3) return sender ? 85 : 8;
    return 0;
  endfunction

  // ------------------------------------------------------------ driver
  always @(posedge clk) begin
    stream_item_t itm;
    if (rst) begin
      stream_if.valid <= 1'b0;
      clear_parse_state();
    end else begin
      if (stream_if.valid && stream_if.ready) begin
        expected_results.push_back(predict_result(stream_if.action, stream_if.data_byte));
        sent_count <= sent_count + 1;
      end
      if (!stream_if.valid || stream_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          itm = pending_items.pop_front();
          stream_if.valid     <= 1'b1;
          stream_if.action    <= itm.action;
          stream_if.data_byte <= itm.data_byte;
        end else begin
          stream_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------ monitor
  always @(posedge clk) begin
    parse_result_t exp_r;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, status %0d", $realtime,
                   result_if.status);
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_if.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime,
                     exp_r.status, result_if.status);
            err_count++;
          end
          if (result_if.payload_byte !== exp_r.payload_byte) begin
            $display("%0t: payload_byte expected %0h actual %0h", $realtime,
                     exp_r.payload_byte, result_if.payload_byte);
            err_count++;
          end
          if (result_if.payload_valid !== exp_r.payload_valid) begin
            $display("%0t: payload_valid expected %0b actual %0b", $realtime,
                     exp_r.payload_valid, result_if.payload_valid);
            err_count++;
          end
        end
      end
      result_if.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ------------------------------------------------------------ sequence
  initial begin
    rst                 = 1'b1;
    stream_if.valid     = 1'b0;
    stream_if.action    = gzhp_pkg::ACT_DATA;
    stream_if.data_byte = '0;
    result_if.ready     = 1'b0;
    item_count  = 0;
    sent_count  = 0;
    err_count   = 0;
    cycle_count = 0;

    // bad first magic, then an end against the pending error
    add_item(gzhp_pkg::ACT_RESTART, 8'h00);
    add_item(gzhp_pkg::ACT_DATA, 8'h00);
    add_item(gzhp_pkg::ACT_END, 8'hff);
    // reserved flag bits
    add_item(gzhp_pkg::ACT_RESTART, 8'hff);
    add_item(gzhp_pkg::ACT_DATA, gzhp_pkg::Magic1);
    add_item(gzhp_pkg::ACT_DATA, gzhp_pkg::Magic2);
    add_item(gzhp_pkg::ACT_DATA, gzhp_pkg::MethodDeflate);
    add_item(gzhp_pkg::ACT_DATA, 8'he0);
    add_item(ActIgnored, 8'hff);
    // extra field of zero length, payload extremes, end, byte after end
    add_item(gzhp_pkg::ACT_RESTART, 8'h00);
    add_item(gzhp_pkg::ACT_DATA, gzhp_pkg::Magic1);
    add_item(gzhp_pkg::ACT_DATA, gzhp_pkg::Magic2);
    add_item(gzhp_pkg::ACT_DATA, gzhp_pkg::MethodDeflate);
    add_item(gzhp_pkg::ACT_DATA, 8'h04);
    repeat (3) begin
      add_item(gzhp_pkg::ACT_DATA, 8'h00);
      add_item(gzhp_pkg::ACT_DATA, 8'hff);
    end
    add_item(gzhp_pkg::ACT_DATA, 8'h00);
    add_item(gzhp_pkg::ACT_DATA, 8'h00);
    add_item(gzhp_pkg::ACT_DATA, 8'hff);
    add_item(gzhp_pkg::ACT_DATA, 8'h00);
    add_item(gzhp_pkg::ACT_END, 8'h00);
    add_item(gzhp_pkg::ACT_DATA, 8'ha5);
    // end inside the header
    add_item(gzhp_pkg::ACT_RESTART, 8'h00);
    add_item(gzhp_pkg::ACT_DATA, gzhp_pkg::Magic1);
    add_item(gzhp_pkg::ACT_END, 8'h00);

    // random part: mostly members, some noise
    while (item_count < 1850) begin
      if ($urandom_range(99) < 6) begin
        repeat ($urandom_range(1, 8))
          add_item(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        add_member();
      end
    end
    total_items = pending_items.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // drain
    do @(negedge clk);
    while (pending_items.size() != 0 || stream_if.valid || expected_results.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
